### hdl/lcd_shadow_framebuffer_pixel_writer_top_macros.svh
// Assertion macros used by the frame engine module (lsfb_back)
`ifndef LCD_SHADOW_FRAMEBUFFER_PIXEL_WRITER_TOP_MACROS_SVH
`define LCD_SHADOW_FRAMEBUFFER_PIXEL_WRITER_TOP_MACROS_SVH

// Plain property, checked outside reset
`define LSFB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication, checked outside reset
`define LSFB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define LSFB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lsfb_pkg.sv
// Shared types and constants for the shadow framebuffer pixel writer
package lsfb_pkg;

    localparam int COLUMNS     = 96;
    localparam int BANKS       = 9;
    localparam int STORE_DEPTH = COLUMNS * BANKS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = 7;
    localparam int BANK_W      = 4;
    localparam int Y_W         = 7;
    localparam int MAX_Y       = (BANKS - 1) * 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Panel command encodings
    localparam logic [7:0] CMD_BANK    = 8'hB0;
    localparam logic [7:0] CMD_COL_HI  = 8'h10;
    localparam logic [7:0] COL_LO_MASK = 8'h0F;
    localparam logic [7:0] COL_HI_MASK = 8'h07;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_MOVE  = 2'd1,
        OP_PLOT  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        MODE_SET    = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_INVERT = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CMD1,
        ST_CMD2,
        ST_DATA
    } t_state;

    // One classified operation, as held in the queue
    typedef struct packed {
        t_op               op;
        logic [7:0]        data_byte;
        logic [COL_W-1:0]  col;
        logic [BANK_W-1:0] bank;
        logic [7:0]        mask;
        logic [1:0]        mode;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

endpackage

### hdl/lsfb_ram.sv
// Generic single-write, single-read RAM with registered read data
module lsfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 864
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/lsfb_front.sv
// Front end: accepts operations, saturates coordinates and classifies them
module lsfb_front (
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_opcode,
    input  logic [7:0]            i_data_byte,
    input  logic [6:0]            i_x,
    input  logic [6:0]            i_y,
    input  logic [1:0]            i_pixel_mode,
    input  logic                  i_q_ready,
    input  logic                  i_clearing,
    output lsfb_pkg::t_push       o_push
);
    import lsfb_pkg::*;

    logic [COL_W-1:0] x_sat;
    logic [Y_W-1:0]   y_sat;
    logic             known_op;

    // Saturate coordinates to the panel area
    always_comb begin
        x_sat = (i_x > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : i_x;
        y_sat = (i_y > Y_W'(MAX_Y)) ? Y_W'(MAX_Y) : i_y;
    end

    // Hold off the sender while the queue is full or the store is clearing
    assign o_stall  = !i_q_ready || i_clearing;

    // Drop unknown opcodes; push everything else
    assign known_op = (i_opcode == OP_WRITE) || (i_opcode == OP_MOVE) ||
                      (i_opcode == OP_PLOT);

    always_comb begin
        o_push.push            = i_valid && !o_stall && known_op;
        o_push.entry.op        = t_op'(i_opcode);
        o_push.entry.data_byte = i_data_byte;
        o_push.entry.col       = x_sat;
        o_push.entry.bank      = BANK_W'(y_sat >> 3);
        o_push.entry.mask      = 8'd1 << y_sat[2:0];
        o_push.entry.mode      = i_pixel_mode;
    end

endmodule

### hdl/lsfb_queue.sv
// Short queue between the front end and the frame engine
module lsfb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lsfb_pkg::t_push i_push,
    output logic            o_ready,
    output lsfb_pkg::t_head o_head,
    input  logic            i_pop
);
    import lsfb_pkg::*;

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_ready      = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign do_push      = i_push.push && o_ready;
    assign do_pop       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rptr];

    // Advance pointers and count
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(r_wptr + 1'b1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(r_rptr + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_count = QCNT_W'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.entry;
        end
    end

endmodule

### hdl/lsfb_back.sv
// Frame engine: owns the cursor and shadow store and emits panel frames
`include "lcd_shadow_framebuffer_pixel_writer_top_macros.svh"

module lsfb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lsfb_pkg::t_head i_head,
    output logic            o_pop,
    output logic            o_clearing,
    input  logic            i_stall,
    output logic            o_valid,
    output logic            o_is_data,
    output logic [7:0]      o_frame_byte,
    output logic            o_last
);
    import lsfb_pkg::*;

    t_state            r_state, n_state;
    logic [COL_W-1:0]  r_col, n_col;
    logic [BANK_W-1:0] r_bank, n_bank;
    t_entry            r_cur, n_cur;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_out_valid;
    logic              r_out_is_data;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    logic              out_free;
    logic              load;
    logic              ld_is_data;
    logic [7:0]        ld_byte;
    logic              ld_last;
    logic [COL_W-1:0]  adv_col;
    logic [BANK_W-1:0] adv_bank;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic [7:0]        plot_byte;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [COL_W-1:0]  col,
                                                     input logic [BANK_W-1:0] bank);
        store_addr = ADDR_W'(col * BANKS + bank);
    endfunction

    lsfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free   = !r_out_valid || !i_stall;
    assign o_clearing = (r_state == ST_CLEAR);

    // Advance the cursor with column and bank wrap
    always_comb begin
        if (r_col == COL_W'(COLUMNS - 1)) begin
            adv_col  = '0;
            adv_bank = (r_bank == BANK_W'(BANKS - 1)) ? '0 : BANK_W'(r_bank + 1'b1);
        end else begin
            adv_col  = COL_W'(r_col + 1'b1);
            adv_bank = r_bank;
        end
    end

    // Apply the pixel mode to the byte read back from the store
    always_comb begin
        case (r_cur.mode)
            MODE_SET:    plot_byte = ram_rdata | r_cur.mask;
            MODE_CLEAR:  plot_byte = ram_rdata & ~r_cur.mask;
            MODE_INVERT: plot_byte = ram_rdata ^ r_cur.mask;
            default:     plot_byte = ram_rdata;
        endcase
    end

    // Sequence the frames of one operation
    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_bank     = r_bank;
        n_cur      = r_cur;
        n_clr_addr = r_clr_addr;
        load       = 1'b0;
        ld_is_data = 1'b0;
        ld_byte    = '0;
        ld_last    = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = store_addr(r_col, r_bank);
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = store_addr(i_head.entry.col, i_head.entry.bank);
        o_pop      = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = ADDR_W'(r_clr_addr + 1'b1);
                end
            end
            ST_IDLE: begin
                if (i_head.valid && out_free) begin
                    o_pop = 1'b1;
                    case (i_head.entry.op)
                        OP_WRITE: begin
                            load       = 1'b1;
                            ld_is_data = 1'b1;
                            ld_byte    = i_head.entry.data_byte;
                            ld_last    = 1'b1;
                            ram_we     = 1'b1;
                            ram_wdata  = i_head.entry.data_byte;
                            n_col      = adv_col;
                            n_bank     = adv_bank;
                        end
                        OP_MOVE, OP_PLOT: begin
                            load    = 1'b1;
                            ld_byte = CMD_BANK | 8'(i_head.entry.bank);
                            n_col   = i_head.entry.col;
                            n_bank  = i_head.entry.bank;
                            ram_re  = (i_head.entry.op == OP_PLOT);
                            n_cur   = i_head.entry;
                            n_state = ST_CMD1;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CMD1: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = 8'(r_cur.col) & COL_LO_MASK;
                    n_state = ST_CMD2;
                end
            end
            ST_CMD2: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = CMD_COL_HI | ((8'(r_cur.col) >> 4) & COL_HI_MASK);
                    ld_last = (r_cur.op == OP_MOVE);
                    n_state = (r_cur.op == OP_MOVE) ? ST_IDLE : ST_DATA;
                end
            end
            ST_DATA: begin
                if (out_free) begin
                    load       = 1'b1;
                    ld_is_data = 1'b1;
                    ld_byte    = plot_byte;
                    ld_last    = 1'b1;
                    ram_we     = 1'b1;
                    ram_wdata  = plot_byte;
                    n_col      = adv_col;
                    n_bank     = adv_bank;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_col       <= '0;
            r_bank      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_bank     <= n_bank;
            r_clr_addr <= n_clr_addr;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the current operation and the output frame
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (load) begin
            r_out_is_data <= ld_is_data;
            r_out_byte    <= ld_byte;
            r_out_last    <= ld_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_is_data    = r_out_is_data;
    assign o_frame_byte = r_out_byte;
    assign o_last       = r_out_last;

    `LSFB_ASSERT_IMP(a_pop_only_idle, o_pop, r_state == ST_IDLE, "queue pop outside idle")
    `LSFB_ASSERT_IMP(a_clear_quiet, r_state == ST_CLEAR, !r_out_valid && !o_pop, "activity during clear")
    `LSFB_ASSERT(a_cursor_range, r_col <= COL_W'(COLUMNS - 1) && r_bank <= BANK_W'(BANKS - 1), "cursor out of range")
    `LSFB_ASSERT_NXT(a_plot_ends_data, r_state == ST_DATA && out_free, r_out_valid && r_out_is_data && r_out_last, "plot did not end in a last data frame")
    `LSFB_ASSERT(a_ram_port_excl, !(ram_we && ram_re), "store read and write in one cycle")

endmodule

### hdl/lcd_shadow_framebuffer_pixel_writer_top.sv
// Top level of the shadow framebuffer pixel writer
//
// Input channel (i_valid / o_stall): one operation per transaction: write a
// data byte at the cursor, move the cursor to a pixel, or plot a pixel with
// set, clear or invert. Unknown opcodes are accepted and dropped.
// Output channel (o_valid / i_stall): one 9-bit panel frame per transaction
// (o_is_data plus o_frame_byte); o_last marks the final frame of an operation.
// An accepted operation lands in a two-entry queue; the frame engine then
// loads its frames into a single output register, one frame per cycle while
// the receiver does not stall, so a write gives 1 frame, a move 3 and a plot 4;
// a plot reads the shadow store while its command frames go out, and writes
// the modified byte back with its data frame.
// After reset the engine sweeps the 864-entry store to zero, one entry per
// cycle; o_stall stays high for that time. When the receiver stalls, the
// output frame holds, the engine pauses, and the queue fills until o_stall
// rises.
module lcd_shadow_framebuffer_pixel_writer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_x,
    input  logic [6:0] i_y,
    input  logic [1:0] i_pixel_mode,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_is_data,
    output logic [7:0] o_frame_byte,
    output logic       o_last
);
    import lsfb_pkg::*;

    t_push push;
    t_head head;
    logic  q_ready;
    logic  pop;
    logic  clearing;

    lsfb_front u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_data_byte  (i_data_byte),
        .i_x          (i_x),
        .i_y          (i_y),
        .i_pixel_mode (i_pixel_mode),
        .i_q_ready    (q_ready),
        .i_clearing   (clearing),
        .o_push       (push)
    );

    lsfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .o_head  (head),
        .i_pop   (pop)
    );

    lsfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_is_data    (o_is_data),
        .o_frame_byte (o_frame_byte),
        .o_last       (o_last)
    );

endmodule

### tb/lsfb_frame_checker.sv
// Scoreboard for the pixel writer: predicts the panel frames of each operation and checks them
module lsfb_frame_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_op_valid,
    input  logic       i_op_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_x,
    input  logic [6:0] i_y,
    input  logic [1:0] i_pixel_mode,
    input  logic       i_frame_valid,
    input  logic       i_frame_stall,
    input  logic       i_is_data,
    input  logic [7:0] i_frame_byte,
    input  logic       i_last,
    output int         o_error_count,
    output int         o_frames_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import lsfb_pkg::*;

    localparam int MAX_PRINTED = 50;

    typedef struct packed {
        logic       is_data;
        logic [7:0] frame_byte;
        logic       last;
    } t_frame;

    // Shadow copy of the store and cursor
    logic [7:0]        shadow_mem [STORE_DEPTH];
    logic [COL_W-1:0]  cur_col;
    logic [BANK_W-1:0] cur_bank;
    t_frame            expected_frames [$];
    int                mismatch_count = 0;
    int                frame_num = 0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("%0t lsfb_frame_checker: frame %0d: %s", $time, frame_num, msg);
        end
    endtask

    task automatic push_frame(input logic is_data, input logic [7:0] val, input logic last);
        t_frame f;
        f.is_data    = is_data;
        f.frame_byte = val;
        f.last       = last;
        expected_frames.push_back(f);
    endtask

    // Store a byte at the cursor, then advance with column and bank wrap
    task automatic store_and_advance(input logic [7:0] val);
        shadow_mem[int'(cur_col) * BANKS + int'(cur_bank)] = val;
        if (int'(cur_col) >= COLUMNS - 1) begin
            cur_col = '0;
            if (int'(cur_bank) >= BANKS - 1) begin
                cur_bank = '0;
            end else begin
                cur_bank = cur_bank + 1'b1;
            end
        end else begin
            cur_col = cur_col + 1'b1;
        end
    endtask

    // Position the cursor and queue the bank, column-low and column-high commands
    task automatic move_cursor(input logic [6:0] xs, input logic [6:0] ys, input logic last);
        logic [7:0] col8;
        col8     = {1'b0, xs};
        cur_col  = xs;
        cur_bank = ys[6:3];
        push_frame(1'b0, CMD_BANK | {4'b0, ys[6:3]}, 1'b0);
        push_frame(1'b0, col8 & COL_LO_MASK, 1'b0);
        push_frame(1'b0, CMD_COL_HI | ((col8 >> 4) & COL_HI_MASK), last);
    endtask

    // Predict the frames of one operation and update the shadow state
    task automatic apply_operation(input logic [1:0] op, input logic [7:0] data,
                                   input logic [6:0] x, input logic [6:0] y,
                                   input logic [1:0] mode);
        logic [6:0] xs;
        logic [6:0] ys;
        logic [7:0] mask;
        logic [7:0] pix;
        xs = (int'(x) > COLUMNS - 1) ? 7'(COLUMNS - 1) : x;
        ys = (int'(y) > MAX_Y) ? 7'(MAX_Y) : y;
        case (op)
            OP_WRITE: begin
                store_and_advance(data);
                push_frame(1'b1, data, 1'b1);
            end
            OP_MOVE: begin
                move_cursor(xs, ys, 1'b1);
            end
            OP_PLOT: begin
                move_cursor(xs, ys, 1'b0);
                mask = 8'd1 << ys[2:0];
                pix  = shadow_mem[int'(cur_col) * BANKS + int'(cur_bank)];
                case (mode)
                    MODE_SET:    pix = pix | mask;
                    MODE_CLEAR:  pix = pix & ~mask;
                    MODE_INVERT: pix = pix ^ mask;
                    default:     pix = pix;
                endcase
                store_and_advance(pix);
                push_frame(1'b1, pix, 1'b1);
            end
            default: begin
                // drop unknown opcodes: no frames, no state change
            end
        endcase
    endtask

    // Compare delivered frames first, then predict for the accepted operation
    always @(posedge i_clk) begin : scoreboard
        t_frame got;
        t_frame want;
        if (!i_rst_n) begin
            foreach (shadow_mem[i]) shadow_mem[i] = '0;
            cur_col  = '0;
            cur_bank = '0;
            expected_frames.delete();
        end else begin
            if (i_frame_valid && !i_frame_stall) begin
                got = {i_is_data, i_frame_byte, i_last};
                if (expected_frames.size() == 0) begin
                    report_mismatch($sformatf("unexpected frame is_data=%0b byte=%02h last=%0b",
                                              got.is_data, got.frame_byte, got.last));
                end else begin
                    want = expected_frames.pop_front();
                    if (got.is_data != want.is_data) begin
                        report_mismatch($sformatf("is_data %0b, want %0b",
                                                  got.is_data, want.is_data));
                    end
                    if (got.frame_byte != want.frame_byte) begin
                        report_mismatch($sformatf("frame_byte %02h, want %02h",
                                                  got.frame_byte, want.frame_byte));
                    end
                    if (got.last != want.last) begin
                        report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
                    end
                end
                frame_num++;
            end
            if (i_op_valid && !i_op_stall) begin
                apply_operation(i_opcode, i_data_byte, i_x, i_y, i_pixel_mode);
            end
        end
        o_error_count <= mismatch_count;
        o_frames_due  <= expected_frames.size();
    end

endmodule

### tb/lcd_shadow_framebuffer_pixel_writer_top_tb.sv
// Testbench top for the pixel writer: clock, reset, operation stimulus and verdict
module lcd_shadow_framebuffer_pixel_writer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lsfb_pkg::*;

    localparam int         CLK_PERIOD   = 8;
    localparam int         RESET_CYCLES = 9;
    localparam int         RANDOM_OPS   = 135;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 32;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [1:0] MODE_KEEP    = 2'd3;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [1:0] i_opcode     = '0;
    logic [7:0] i_data_byte  = '0;
    logic [6:0] i_x          = '0;
    logic [6:0] i_y          = '0;
    logic [1:0] i_pixel_mode = '0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_is_data;
    logic [7:0] o_frame_byte;
    logic       o_last;

    int error_count;
    int frames_due;
    int cycle_count = 0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;
    bit no_idle     = 1'b0;

    lcd_shadow_framebuffer_pixel_writer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_data_byte  (i_data_byte),
        .i_x          (i_x),
        .i_y          (i_y),
        .i_pixel_mode (i_pixel_mode),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_is_data    (o_is_data),
        .o_frame_byte (o_frame_byte),
        .o_last       (o_last)
    );

    lsfb_frame_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op_valid    (i_valid),
        .i_op_stall    (o_stall),
        .i_opcode      (i_opcode),
        .i_data_byte   (i_data_byte),
        .i_x           (i_x),
        .i_y           (i_y),
        .i_pixel_mode  (i_pixel_mode),
        .i_frame_valid (o_valid),
        .i_frame_stall (i_stall),
        .i_is_data     (o_is_data),
        .i_frame_byte  (o_frame_byte),
        .i_last        (o_last),
        .o_error_count (error_count),
        .o_frames_due  (frames_due)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // End the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lcd_shadow_framebuffer_pixel_writer_top_tb: done, errors");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one operation and hold it until the transaction completes
    task automatic send_op(input logic [1:0] op, input logic [7:0] data, input logic [6:0] x,
                           input logic [6:0] y, input logic [1:0] mode);
        int gap;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_data_byte  <= data;
        i_x          <= x;
        i_y          <= y;
        i_pixel_mode <= mode;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stop offering and wait for every predicted frame to arrive
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (frames_due != 0) @(posedge i_clk);
    endtask

    // Frame receiver: random stalls, one long hold-off on request
    initial begin : frame_sink
        int len;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (no_idle) begin
                i_stall <= 1'b0;
                len = 1;
            end else if (hold_req && !hold_done) begin
                i_stall <= 1'b1;
                len = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < 35);
                len = idle_len() + 1;
            end
            repeat (len) @(posedge i_clk);
        end
    end

    // Operation source and verdict
    initial begin : op_source
        int         r;
        logic [1:0] op;
        logic [1:0] mode;
        logic [6:0] x;
        logic [6:0] y;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: byte extremes, cursor wrap, saturation, every mode and opcode
        send_op(OP_WRITE, 8'h00, 7'd0, 7'd0, MODE_SET);
        send_op(OP_WRITE, 8'hFF, 7'd0, 7'd0, MODE_SET);
        send_op(OP_WRITE, 8'hA5, 7'd0, 7'd0, MODE_SET);
        send_op(OP_MOVE, 8'h00, 7'd95, 7'd64, MODE_SET);
        send_op(OP_WRITE, 8'h5A, 7'd0, 7'd0, MODE_SET);
        send_op(OP_MOVE, 8'h00, 7'd127, 7'd127, MODE_SET);
        send_op(OP_PLOT, 8'h00, 7'd0, 7'd0, MODE_SET);
        send_op(OP_PLOT, 8'h00, 7'd0, 7'd7, MODE_INVERT);
        send_op(OP_PLOT, 8'h00, 7'd0, 7'd0, MODE_CLEAR);
        send_op(OP_PLOT, 8'h00, 7'd0, 7'd7, MODE_KEEP);
        send_op(OP_UNUSED, 8'h3C, 7'd17, 7'd9, MODE_SET);
        send_op(OP_MOVE, 8'h00, 7'd95, 7'd7, MODE_SET);
        send_op(OP_WRITE, 8'hC3, 7'd0, 7'd0, MODE_SET);
        send_op(OP_WRITE, 8'h3C, 7'd0, 7'd0, MODE_SET);
        send_op(OP_PLOT, 8'h00, 7'd95, 7'd64, MODE_INVERT);
        send_op(OP_WRITE, 8'h7E, 7'd0, 7'd0, MODE_SET);
        send_op(OP_PLOT, 8'h00, 7'd100, 7'd70, MODE_SET);
        send_op(OP_PLOT, 8'h00, 7'd64, 7'd33, MODE_SET);
        send_op(OP_PLOT, 8'h00, 7'd64, 7'd33, MODE_INVERT);
        send_op(OP_MOVE, 8'h00, 7'd1, 7'd63, MODE_SET);
        send_op(OP_WRITE, 8'h80, 7'd0, 7'd0, MODE_SET);
        send_op(OP_WRITE, 8'h01, 7'd0, 7'd0, MODE_SET);
        send_op(OP_PLOT, 8'h00, 7'd42, 7'd42, MODE_KEEP);
        send_op(OP_UNUSED, 8'hFF, 7'd127, 7'd127, MODE_KEEP);
        send_op(OP_MOVE, 8'h00, 7'd0, 7'd0, MODE_SET);

        // Random: mostly plots and writes, hot spots in the last columns and first two banks
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == 40) hold_req = 1'b1;
            if (n == 100) wait_drained();
            no_idle = (n >= 110 && n < 140);

            r = $urandom_range(0, 99);
            if (r < 30) op = OP_WRITE;
            else if (r < 55) op = OP_MOVE;
            else if (r < 95) op = OP_PLOT;
            else op = OP_UNUSED;

            r = $urandom_range(0, 99);
            if (r < 70) x = 7'($urandom_range(0, COLUMNS - 1));
            else if (r < 80) x = 7'($urandom_range(COLUMNS, 127));
            else x = 7'($urandom_range(COLUMNS - 4, COLUMNS - 1));

            r = $urandom_range(0, 99);
            if (r < 70) y = 7'($urandom_range(0, MAX_Y));
            else if (r < 80) y = 7'($urandom_range(MAX_Y + 1, 127));
            else y = 7'($urandom_range(0, 15));

            r = $urandom_range(0, 99);
            if (r < 30) mode = MODE_SET;
            else if (r < 60) mode = MODE_CLEAR;
            else if (r < 95) mode = MODE_INVERT;
            else mode = MODE_KEEP;

            send_op(op, 8'($urandom), x, y, mode);
        end

        // Drain, then give stray frames time to show up
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && frames_due == 0) begin
            $display("lcd_shadow_framebuffer_pixel_writer_top_tb: done, clean");
        end else begin
            $display("lcd_shadow_framebuffer_pixel_writer_top_tb: done, errors");
        end
        $finish;
    end

endmodule
